// ===== src/wllo_pkg.sv =====
// Shared types and constants for the window/level label overlay pipeline.
// No dependencies; imported by every module of the block except wllo_ram.
package wllo_pkg;

	localparam int unsigned LABEL_COUNT_DEF = 255;
	localparam int unsigned LABEL_W = 8;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned OPACITY_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPACITY = 2'd2;

	localparam logic [31:0] GAIN_RESET = 32'h0001_0000;
	localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;
	localparam logic [OPACITY_W-1:0] OPACITY_RESET = 9'd128;
	localparam logic [OPACITY_W-1:0] OPACITY_ONE = 9'd256;

	localparam logic signed [48:0] GREY_MAX_Q16 = 49'sd16711680;

	localparam logic OP_RENDER = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
	} pipe_ctl_t;

endpackage

// ===== src/wllo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the label colour table.
module wllo_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 255,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/wllo_grey.sv =====
// Grey mapping: Q16.16 gain multiply (stage 2), offset add and clamp (stage 3).
// Depends on wllo_pkg.
module wllo_grey (
	input  logic                                clk,
	input  wllo_pkg::pipe_ctl_t                 ctl,
	input  logic signed [wllo_pkg::SAMPLE_W-1:0] sample_s1,
	input  logic [31:0]                         gain,
	input  logic [31:0]                         level_offset,
	output logic [7:0]                          grey_s3
);
	import wllo_pkg::*;

	logic signed [47:0] prod_s2;
	logic signed [48:0] sum;

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			prod_s2 <= $signed(gain) * sample_s1;
		end
	end

	assign sum = $signed({prod_s2[47], prod_s2})
		+ $signed({{17{level_offset[31]}}, level_offset});

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			if (sum[48]) begin
				grey_s3 <= 8'd0;
			end else if (sum >= GREY_MAX_Q16) begin
				grey_s3 <= 8'd255;
			end else begin
				grey_s3 <= sum[23:16];
			end
		end
	end

endmodule

// ===== src/wllo_blend.sv =====
// Label colour blend per channel and output select (stage 4).
// Depends on wllo_pkg.
module wllo_blend (
	input  logic                                 clk,
	input  wllo_pkg::pipe_ctl_t                  ctl,
	input  logic [7:0]                           grey_s3,
	input  wllo_pkg::rgb_t                       colour_s3,
	input  logic                                 overlay_s3,
	input  logic [wllo_pkg::OPACITY_W-1:0]       opacity,
	output wllo_pkg::rgb_t                       pix_s4
);
	import wllo_pkg::*;

	function automatic logic [7:0] mix(input logic [7:0] g, input logic [7:0] c,
			input logic [OPACITY_W-1:0] op);
		logic signed [8:0]  diff;
		logic signed [18:0] prod;
		logic signed [19:0] num;
		diff = $signed({1'b0, c}) - $signed({1'b0, g});
		prod = $signed({1'b0, op}) * diff;
		num = $signed({4'd0, g, 8'd0}) + $signed({prod[18], prod});
		return num[19] ? 8'd0 : num[15:8];
	endfunction

	rgb_t mixed;

	always_comb begin
		mixed.red = mix(grey_s3, colour_s3.red, opacity);
		mixed.green = mix(grey_s3, colour_s3.green, opacity);
		mixed.blue = mix(grey_s3, colour_s3.blue, opacity);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld4) begin
			if (overlay_s3) begin
				pix_s4 <= mixed;
			end else begin
				pix_s4 <= '{red: grey_s3, green: grey_s3, blue: grey_s3};
			end
		end
	end

endmodule

// ===== src/window_level_label_overlay.sv =====
// Top level: window/level grey mapping with label color overlay, four stages.
// Depends on wllo_pkg, wllo_ram, wllo_grey, wllo_blend.
//
// channel   direction  payload
// s_axis    in         tuser: operation; tdata: sample, label, entry_index, rgb
// m_axis    out        tuser: overlaid; tdata: red, green, blue
// cfg       in         gain, level_offset, opacity by index
//
// One transaction per cycle unless m_axis stalls; a render pixel reaches m_axis from the stage 4 register.
// Stage 1 input register, stage 2 gain multiply and color table read,
// stage 3 offset add and clamp, stage 4 blend into the output register.
// Each stage advances when it is empty or the next one advances; bubbles collapse.
// Table writes take effect as they leave stage 1 and produce no output.
// arst_n clears the valid bits and the config registers; data registers and the color table are not cleared.
module window_level_label_overlay #(
	parameter int unsigned LABEL_COUNT = wllo_pkg::LABEL_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// sample, label, entry_index, new_red, new_green, new_blue
	input  logic [55:0]                     s_axis_tdata,
	input  logic                            s_axis_tuser,  // operation
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [23:0]                     m_axis_tdata,  // red, green, blue
	output logic                            m_axis_tuser,  // overlaid
	input  logic                            cfg_we,
	input  logic [wllo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wllo_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wllo_pkg::*;

	localparam int unsigned TABLE_DEPTH = (LABEL_COUNT > 255) ? 255 : LABEL_COUNT;
	localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [15:0] LAST_LABEL = 16'(LABEL_COUNT);

	logic [31:0]          gain_q;
	logic [31:0]          offset_q;
	logic [OPACITY_W-1:0] opacity_q;
	logic [OPACITY_W-1:0] opacity_eff;

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic                        op_s1;
	logic signed [SAMPLE_W-1:0]  sample_s1;
	logic [LABEL_W-1:0]          label_s1;
	logic [LABEL_W-1:0]          entry_s1;
	rgb_t                        new_s1;
	logic                        overlay_s2, overlay_s3, overlay_s4;
	rgb_t                        colour_s2, colour_s3;
	logic [7:0]                  grey_s3;
	rgb_t                        pix_s4;

	logic        rdy1, rdy2, rdy3, rdy4;
	pipe_ctl_t   ctl;
	logic        label_hit;
	logic        entry_hit;
	logic        ram_we;
	logic [7:0]  waddr_full;
	logic [7:0]  raddr_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			offset_q <= OFFSET_RESET;
			opacity_q <= OPACITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN: gain_q <= cfg_wdata;
				CFG_LEVEL_OFFSET: offset_q <= cfg_wdata;
				CFG_OPACITY: opacity_q <= cfg_wdata[OPACITY_W-1:0];
				default: ;
			endcase
		end
	end

	assign opacity_eff = (opacity_q > OPACITY_ONE) ? OPACITY_ONE : opacity_q;

	assign rdy4 = !v_s4 || m_axis_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;
	assign ctl = '{ld2: rdy2, ld3: rdy3, ld4: rdy4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1 && (op_s1 == OP_RENDER);
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1 <= s_axis_tuser;
			sample_s1 <= $signed(s_axis_tdata[15:0]);
			label_s1 <= s_axis_tdata[23:16];
			entry_s1 <= s_axis_tdata[31:24];
			new_s1 <= '{red: s_axis_tdata[39:32], green: s_axis_tdata[47:40],
				blue: s_axis_tdata[55:48]};
		end
		if (rdy2) begin
			overlay_s2 <= label_hit;
		end
		if (rdy3) begin
			overlay_s3 <= overlay_s2;
			colour_s3 <= colour_s2;
		end
		if (rdy4) begin
			overlay_s4 <= overlay_s3;
		end
	end

	assign label_hit = (label_s1 != '0) && ({8'd0, label_s1} <= LAST_LABEL);
	assign entry_hit = (entry_s1 != '0) && ({8'd0, entry_s1} <= LAST_LABEL);
	assign ram_we = v_s1 && (op_s1 == OP_WRITE) && entry_hit && rdy2;
	assign waddr_full = entry_s1 - 8'd1;
	assign raddr_full = label_s1 - 8'd1;

	wllo_ram #(
		.WIDTH ($bits(rgb_t)),
		.DEPTH (TABLE_DEPTH),
		.ADDR_W(ADDR_W)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr_full[ADDR_W-1:0]),
		.wdata(new_s1),
		.re   (rdy2),
		.raddr(raddr_full[ADDR_W-1:0]),
		.rdata(colour_s2)
	);

	wllo_grey u_grey (
		.clk         (clk),
		.ctl         (ctl),
		.sample_s1   (sample_s1),
		.gain        (gain_q),
		.level_offset(offset_q),
		.grey_s3     (grey_s3)
	);

	wllo_blend u_blend (
		.clk       (clk),
		.ctl       (ctl),
		.grey_s3   (grey_s3),
		.colour_s3 (colour_s3),
		.overlay_s3(overlay_s3),
		.opacity   (opacity_eff),
		.pix_s4    (pix_s4)
	);

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata = {pix_s4.blue, pix_s4.green, pix_s4.red};
	assign m_axis_tuser = overlay_s4;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled while a stage is empty");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (v_s1 && (op_s1 == OP_WRITE)))
		else $error("table write without a write transaction");

	a_plain_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !overlay_s4) |->
			(pix_s4.red == pix_s4.green && pix_s4.green == pix_s4.blue))
		else $error("unlabeled pixel is not grey");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (op_s1 == OP_WRITE) && rdy2) |=> !v_s2)
		else $error("write transaction entered the result path");

endmodule
